// ----- src/led_pattern_generator_unit_macros.svh -----
// Assertion macros shared by the LED pattern generator RTL.
`ifndef LED_PATTERN_GENERATOR_UNIT_MACROS_SVH
`define LED_PATTERN_GENERATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LPG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPG_ASSERT(label, clk, rst_n, prop, msg)
`define LPG_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- src/lpg_pkg.sv -----
// Package with mode codes, widths and the SOS duration table of the LED pattern generator.
package lpg_pkg;

    localparam int SOS_LENGTH = 18;
    localparam int SOS_IDX_W  = 5;
    localparam int DUR_W      = 11;
    localparam int SLOW_W     = 16;
    localparam int TIME_W     = 32;
    localparam int MODE_W     = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam logic [TIME_W-1:0] FAST_INTERVAL_MS = TIME_W'(50);
    localparam logic [SLOW_W-1:0] SLOW_RESET_MS    = SLOW_W'(250);

    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SOLID = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SLOW  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FAST  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SOS   = 3'd4;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SET    = 1'b1;

    localparam logic [DUR_W-1:0] SOS_DURATIONS [32] = '{
        11'd150, 11'd150, 11'd150, 11'd150, 11'd150, 11'd450,
        11'd450, 11'd150, 11'd450, 11'd150, 11'd450, 11'd450,
        11'd150, 11'd150, 11'd150, 11'd150, 11'd150, 11'd1500,
        11'd150, 11'd150, 11'd150, 11'd150, 11'd150, 11'd450,
        11'd450, 11'd150, 11'd450, 11'd150, 11'd450, 11'd450,
        11'd150, 11'd150
    };

    function automatic logic [SOS_IDX_W-1:0] next_sos_step(input logic [SOS_IDX_W-1:0] step);
        logic [SOS_IDX_W:0] n;
        n = {1'b0, step} + (SOS_IDX_W+1)'(1);
        if (n >= (SOS_IDX_W+1)'(SOS_LENGTH)) begin
            n = '0;
        end
        return n[SOS_IDX_W-1:0];
    endfunction

endpackage

// ----- src/led_pattern_generator_unit.sv -----
// LED pattern generator: input register, mode and timing update, result register.
//
//   channel   | dir | accepted when             | payload
//   s_axis    | in  | s_tvalid && s_tready      | tuser op, tdata mode/now_ms
//   m_axis    | out | m_tvalid && m_tready      | tdata led_on/pin_level
//   cfg       | in  | cfg_we                    | slow_interval_ms
//
// One transfer per cycle while the result is taken; each item passes from the input
// register into the single state-update stage, which writes the result register.
// aresetn (synchronous, active low) clears mode, timing, LED and SOS state, both
// valid flags and restores slow_interval_ms to 250.
// A stalled result holds the update stage; the input register keeps taking an item
// until it too is full.
`include "led_pattern_generator_unit_macros.svh"

module led_pattern_generator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lpg_pkg::SLOW_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lpg_pkg::S_TDATA_W-1:0] s_tdata,   // [2:0] mode, [34:3] now_ms, zero fill
    input  logic                          s_tuser,   // [0] op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lpg_pkg::M_TDATA_W-1:0] m_tdata    // [0] led_on, [1] pin_level, zero fill
);
    import lpg_pkg::*;

    logic [SLOW_W-1:0]    slow_reg;
    logic                 in_valid_reg;
    logic                 in_op_reg;
    logic [MODE_W-1:0]    in_mode_reg;
    logic [TIME_W-1:0]    in_now_reg;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [TIME_W-1:0]    last_reg, last_next;
    logic                 lit_reg, lit_next;
    logic [SOS_IDX_W-1:0] sos_reg, sos_next;
    logic                 out_valid_reg;
    logic                 out_lit_reg;
    logic                 advance;
    logic [TIME_W-1:0]    elapsed;
    logic [DUR_W-1:0]     sos_dur;
    logic [SOS_IDX_W-1:0] sos_step;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, ~out_lit_reg, out_lit_reg};

    assign elapsed  = in_now_reg - last_reg;
    assign sos_dur  = SOS_DURATIONS[sos_reg];
    assign sos_step = next_sos_step(sos_reg);

    always_comb begin
        mode_next = mode_reg;
        last_next = last_reg;
        lit_next  = lit_reg;
        sos_next  = sos_reg;
        if (in_op_reg == OP_SET) begin
            mode_next = in_mode_reg;
            last_next = in_now_reg;
            sos_next  = '0;
            if (in_mode_reg == MODE_SOLID) begin
                lit_next = 1'b1;
            end else if (in_mode_reg == MODE_OFF) begin
                lit_next = 1'b0;
            end
        end else begin
            unique case (mode_reg)
                MODE_SLOW: begin
                    if (elapsed >= TIME_W'(slow_reg)) begin
                        last_next = in_now_reg;
                        lit_next  = !lit_reg;
                    end
                end
                MODE_FAST: begin
                    if (elapsed >= FAST_INTERVAL_MS) begin
                        last_next = in_now_reg;
                        lit_next  = !lit_reg;
                    end
                end
                MODE_SOS: begin
                    if (elapsed >= TIME_W'(sos_dur)) begin
                        last_next = in_now_reg;
                        sos_next  = sos_step;
                        lit_next  = sos_reg[0] ? 1'b1 : !sos_step[0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_reg <= SLOW_RESET_MS;
        end else if (cfg_we) begin
            slow_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_mode_reg <= s_tdata[MODE_W-1:0];
            in_now_reg  <= s_tdata[MODE_W +: TIME_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_OFF;
            last_reg      <= '0;
            lit_reg       <= 1'b0;
            sos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                mode_reg <= mode_next;
                last_reg <= last_next;
                lit_reg  <= lit_next;
                sos_reg  <= sos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_lit_reg <= lit_next;
        end
    end

    `LPG_ASSERT(a_sos_in_range, aclk, aresetn,
        {1'b0, sos_reg} < (SOS_IDX_W+1)'(SOS_LENGTH), "SOS step out of range")
    `LPG_ASSERT(a_solid_lights, aclk, aresetn,
        advance && in_valid_reg && in_op_reg == OP_SET && in_mode_reg == MODE_SOLID
        |=> lit_reg && out_lit_reg, "solid mode did not light LED")
    `LPG_ASSERT(a_off_darkens, aclk, aresetn,
        advance && in_valid_reg && in_op_reg == OP_SET && in_mode_reg == MODE_OFF
        |=> !lit_reg && !out_lit_reg, "off mode did not darken LED")
    `LPG_ASSERT(a_ready_stall, aclk, aresetn,
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready,
        "input stalled without a held result")
    `LPG_ASSERT(a_result_matches_state, aclk, aresetn,
        out_valid_reg |-> out_lit_reg == lit_reg, "result disagrees with LED state")
    `LPG_ASSERT_ALWAYS(a_reset_clears, aclk,
        !aresetn |=> !m_tvalid && !lit_reg && !in_valid_reg, "reset left state behind")

endmodule
